// ===== rtl/ecgr_pkg.sv =====
package ecgr_pkg;

	typedef struct packed {
		logic [15:0]        processed_sample;
		logic signed [15:0] raw_sample;
		logic [31:0]        packet_number;
	} in_word_t;

	typedef struct packed {
		logic        r_found;
		logic [31:0] r_packet;
		logic [15:0] r_offset;
		logic [15:0] heart_rate;
	} out_word_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture input word
		logic track;     // update counters, peak, window sum
		logic div_start; // start shared divider
		logic div_hr;    // divider operands: 1 heart rate, 0 threshold
		logic div_step;  // one restoring step
		logic thr_load;  // take new threshold from the quotient
		logic decide;    // compare with threshold, write rr ring on a beat
		logic finish;    // commit results
	} ctrl_t;

	// datapath to controller
	typedef struct packed {
		logic win_close;
		logic beat;
	} stat_t;

	localparam logic [10:0] RR_RESET     = 11'd220;
	localparam logic [8:0]  HR_SCALE     = 9'd480;
	localparam logic [15:0] THRESH_RESET = 16'd8;
	localparam int          DIV_W        = 27;
	localparam logic [1:0]  REG_SAMPLE_RATE = 2'd0;

endpackage

// ===== rtl/ecgr_ctrl.sv =====
module ecgr_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	input  ecgr_pkg::stat_t st,
	output ecgr_pkg::ctrl_t cmd
);

	typedef enum logic [2:0] {IDLE, TRACK, TDIV, DECIDE, HSTART, HDIV, FIN} state_t;
	state_t state_q;
	logic [4:0] cnt_q;
	logic ov_q;

	assign in_stall  = (state_q != IDLE);
	assign out_valid = ov_q;

	always_comb begin
		cmd = '0;
		cmd.load      = (state_q == IDLE) && in_valid && !in_stall;
		cmd.track     = (state_q == TRACK);
		cmd.div_hr    = (state_q == HSTART);
		cmd.div_start = (state_q == TRACK && st.win_close) || (state_q == HSTART);
		cmd.div_step  = (state_q == TDIV || state_q == HDIV) && (cnt_q != 5'd0);
		cmd.thr_load  = (state_q == TDIV) && (cnt_q == 5'd0);
		cmd.decide    = (state_q == DECIDE);
		// commit waits until the previous word has left
		cmd.finish    = (state_q == FIN) && (!ov_q || !out_stall);
	end

	// sequencing: track, threshold divide when the window closes, decide, heart rate divide on a beat, commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			cnt_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (ov_q && !out_stall) ov_q <= 1'b0;
			unique case (state_q)
				IDLE: if (cmd.load) state_q <= TRACK;
				TRACK: begin
					if (st.win_close) begin
						state_q <= TDIV;
						cnt_q   <= 5'(ecgr_pkg::DIV_W);
					end else state_q <= DECIDE;
				end
				TDIV: begin
					if (cnt_q != 5'd0) cnt_q <= cnt_q - 5'd1;
					else state_q <= DECIDE;
				end
				DECIDE: begin
					if (st.beat) state_q <= HSTART;
					else state_q <= FIN;
				end
				HSTART: begin
					state_q <= HDIV;
					cnt_q   <= 5'(ecgr_pkg::DIV_W);
				end
				HDIV: begin
					if (cnt_q != 5'd0) cnt_q <= cnt_q - 5'd1;
					else state_q <= FIN;
				end
				FIN: begin
					if (cmd.finish) begin
						state_q <= IDLE;
						ov_q    <= 1'b1;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/ecgr_datapath.sv =====
module ecgr_datapath #(
	parameter int BUFFER_DEPTH = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [10:0]         sample_rate,
	input  ecgr_pkg::in_word_t  in_word,
	input  ecgr_pkg::ctrl_t     cmd,
	output ecgr_pkg::stat_t     st,
	output ecgr_pkg::out_word_t out_word
);

	localparam int SC_W = $clog2(BUFFER_DEPTH);
	localparam int DW = ecgr_pkg::DIV_W;

	ecgr_pkg::in_word_t in_q;
	logic [31:0] last_packet_q, peak_packet_q, report_packet_q;
	logic [15:0] point_q, peak_offset_q, report_offset_q, rate_q, thr_q;
	logic signed [15:0] peak_value_q;
	logic [10:0] rr_q, win_pos_q;
	logic [SC_W-1:0] sc_q;
	logic [26:0] win_sum_q;
	logic above_q, beat_q, full_q, found_q;
	logic [10:0] ring_q [8];
	logic [2:0] ring_idx_q;
	logic [13:0] ring_sum_q;

	// divider state
	logic [DW-1:0] quo_q, rem_q, dvs_q;

	// combinational tracking of the current word
	logic [SC_W-1:0] sc_n;
	logic [15:0] point_n;
	logic new_peak;
	logic [26:0] wsum_n;
	logic [10:0] wpos_n;
	logic full_n;
	logic proc_above;
	assign sc_n     = sc_q + 1'b1;
	assign point_n  = (last_packet_q != in_q.packet_number) ? 16'd1 : point_q + 16'd1;
	assign new_peak = in_q.raw_sample > peak_value_q;
	assign wsum_n   = win_sum_q + 27'(in_q.processed_sample);
	assign wpos_n   = win_pos_q + 11'd1;
	assign full_n   = sc_n >= SC_W'(BUFFER_DEPTH - 1);

	// threshold compare against the threshold already updated for this word
	assign proc_above = in_q.processed_sample > thr_q;

	assign st.win_close = (sample_rate != 11'd0) && (wpos_n >= sample_rate);
	assign st.beat = !full_q && proc_above && !above_q;

	logic [DW:0] trial;
	assign trial = {rem_q, quo_q[DW-1]} - {1'b0, dvs_q};

	logic [16:0] thr_avg;
	assign thr_avg = 17'(thr_q) + 17'(quo_q);

	logic [13:0] ring_sum_n;
	always_comb begin
		ring_sum_n = '0;
		for (int i = 0; i < 8; i++)
			ring_sum_n = ring_sum_n + 14'(ring_q[i]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_packet_q <= '0; point_q <= '0; peak_value_q <= '0;
			peak_packet_q <= '0; peak_offset_q <= '0; rr_q <= '0; sc_q <= '0;
			ring_idx_q <= '0; win_pos_q <= '0; win_sum_q <= '0;
			thr_q <= ecgr_pkg::THRESH_RESET; above_q <= 1'b0;
			report_packet_q <= '0; report_offset_q <= '0; rate_q <= '0;
			beat_q <= 1'b0; full_q <= 1'b0; found_q <= 1'b0;
			for (int i = 0; i < 8; i++) ring_q[i] <= ecgr_pkg::RR_RESET;
		end else begin
			if (cmd.track) begin
				sc_q <= sc_n;
				last_packet_q <= in_q.packet_number;
				point_q <= point_n;
				if (new_peak) begin
					peak_value_q  <= in_q.raw_sample;
					rr_q          <= 11'(sc_n);
					peak_packet_q <= in_q.packet_number;
					peak_offset_q <= point_n;
				end
				if (sample_rate == 11'd0 || st.win_close) begin
					win_pos_q <= '0; win_sum_q <= '0;
				end else begin
					win_pos_q <= wpos_n; win_sum_q <= wsum_n;
				end
				full_q <= full_n;
			end
			// threshold update once its quotient is ready
			if (cmd.thr_load) thr_q <= thr_avg[16:1];
			// rising edge above threshold and rr ring write
			if (cmd.decide) begin
				above_q <= proc_above;
				beat_q  <= st.beat;
				if (st.beat) begin
					ring_q[ring_idx_q] <= rr_q;
					ring_idx_q <= ring_idx_q + 3'd1;
				end
			end
			if (cmd.finish) begin
				found_q <= beat_q;
				if (full_q) begin
					rate_q <= '0; rr_q <= '0; peak_value_q <= '0; sc_q <= '0;
				end else if (beat_q) begin
					report_packet_q <= peak_packet_q;
					report_offset_q <= peak_offset_q;
					rr_q <= '0; peak_value_q <= '0;
					if (ring_sum_q == 14'd0) rate_q <= '0;
					else if (quo_q > 27'hFFFF) rate_q <= 16'hFFFF;
					else rate_q <= quo_q[15:0];
				end
			end
		end
	end

	// payload and shared restoring divider
	always_ff @(posedge clk) begin
		if (cmd.load) in_q <= in_word;
		if (cmd.div_start) begin
			rem_q <= '0;
			if (!cmd.div_hr) begin
				quo_q <= wsum_n;
				dvs_q <= 27'(sample_rate);
			end else begin
				quo_q <= 27'(ecgr_pkg::HR_SCALE) * 27'(sample_rate);
				dvs_q <= (ring_sum_n == 14'd0) ? 27'd1 : 27'(ring_sum_n);
				ring_sum_q <= ring_sum_n;
			end
		end else if (cmd.div_step) begin
			if (!trial[DW]) begin
				rem_q <= trial[DW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DW-2:0], quo_q[DW-1]};
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
	end

	assign out_word.r_found    = found_q;
	assign out_word.r_packet   = report_packet_q;
	assign out_word.r_offset   = report_offset_q;
	assign out_word.heart_rate = rate_q;

endmodule

// ===== rtl/ecg_r_wave_detector.sv =====
// an accepted word is tracked, divided for the threshold when the threshold window
// closes, compared, divided for the heart rate on a beat, then committed (27-step shared
// restoring divider); one word in flight, the next taken after the commit; a waiting
// result holds back only the commit, not the input
// reset: arst_n clears detector state at once; threshold 8, rr ring 220, sample rate 250
module ecg_r_wave_detector #(
	parameter int BUFFER_DEPTH = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  ecgr_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output ecgr_pkg::out_word_t out_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [1:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	ecgr_pkg::ctrl_t cmd;
	ecgr_pkg::stat_t st;
	logic [10:0] rate_q;

	assign pready = 1'b1;
	assign prdata = (paddr == ecgr_pkg::REG_SAMPLE_RATE) ? {21'd0, rate_q} : 32'd0;

	// sample rate register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rate_q <= 11'd250;
		else if (psel && penable && pwrite && paddr == ecgr_pkg::REG_SAMPLE_RATE)
			rate_q <= pwdata[10:0];
	end

	ecgr_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .st, .cmd
	);

	ecgr_datapath #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_dp (
		.clk, .arst_n, .sample_rate(rate_q), .in_word(in_data), .cmd, .st,
		.out_word(out_data)
	);

endmodule

// ===== test/tb_ecg_r_wave_detector.sv =====
`timescale 1ns / 100ps

module tb_ecg_r_wave_detector;

	localparam int BUF_DEPTH = 1024;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	ecgr_pkg::in_word_t  in_data;
	logic      out_valid;
	logic      out_stall;
	ecgr_pkg::out_word_t out_data;
	logic      psel;
	logic      penable;
	logic      pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	ecg_r_wave_detector #(.BUFFER_DEPTH(BUF_DEPTH)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// detector model state
	logic [10:0] m_rate;
	int unsigned m_last_pkt, m_point, m_peak_pkt, m_peak_off, m_rr_dist, m_count;
	int          m_peak_val;
	int unsigned m_ring [8];
	int unsigned m_ring_idx, m_win_pos, m_win_sum, m_thresh;
	bit          m_above;
	int unsigned m_rep_pkt, m_rep_off, m_hr;

	ecgr_pkg::out_word_t beat_queue [$];
	int        send_idle_pct;
	int        recv_idle_pct;
	int        mismatches;
	int        words_sent;
	int        words_checked;
	int        beats_seen;

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit
	initial begin
		#20ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic model_reset();
		m_rate = 11'd250;
		m_last_pkt = 0; m_point = 0; m_peak_val = 0; m_peak_pkt = 0; m_peak_off = 0;
		m_rr_dist = 0; m_count = 0; m_ring_idx = 0; m_win_pos = 0; m_win_sum = 0;
		m_thresh = 32'(ecgr_pkg::THRESH_RESET); m_above = 0;
		m_rep_pkt = 0; m_rep_off = 0; m_hr = 0;
		foreach (m_ring[i]) m_ring[i] = 32'(ecgr_pkg::RR_RESET);
	endtask

	// predict the result word for one accepted sample
	task automatic predict_beat(input ecgr_pkg::in_word_t w);
		ecgr_pkg::out_word_t r;
		bit          edge_hit;
		bit          found;
		int unsigned sum;
		int unsigned hr;
		edge_hit = 0;
		found = 0;
		m_count++;
		if (m_last_pkt != w.packet_number) begin
			m_point = 1;
			m_last_pkt = w.packet_number;
		end else begin
			m_point = (m_point + 1) & 16'hFFFF;
		end
		if (int'(w.raw_sample) > m_peak_val) begin
			m_peak_val = int'(w.raw_sample);
			m_rr_dist = m_count & 11'h7FF;
			m_peak_pkt = w.packet_number;
			m_peak_off = m_point;
		end
		// adaptive threshold window
		if (m_rate != 0) begin
			m_win_sum += 32'(w.processed_sample);
			m_win_pos++;
			if (m_win_pos >= m_rate) begin
				m_thresh = ((m_thresh + m_win_sum / m_rate) / 2) & 16'hFFFF;
				m_win_pos = 0;
				m_win_sum = 0;
			end
		end else begin
			m_win_pos = 0;
			m_win_sum = 0;
		end
		if (w.processed_sample > m_thresh) begin
			edge_hit = !m_above;
			m_above = 1;
		end else begin
			m_above = 0;
		end
		// buffer full wins over a beat
		if (m_count >= BUF_DEPTH - 1) begin
			m_hr = 0; m_rr_dist = 0; m_peak_val = 0; m_count = 0;
		end else if (edge_hit) begin
			m_rep_pkt = m_peak_pkt;
			m_rep_off = m_peak_off;
			m_ring[m_ring_idx] = m_rr_dist & 11'h7FF;
			m_ring_idx = (m_ring_idx + 1) & 7;
			sum = 0;
			foreach (m_ring[i]) sum += m_ring[i];
			if (sum == 0) begin
				m_hr = 0;
			end else begin
				hr = 480 * m_rate / sum;
				m_hr = (hr > 16'hFFFF) ? 16'hFFFF : hr;
			end
			m_rr_dist = 0;
			m_peak_val = 0;
			found = 1;
		end
		r.r_found = found;
		r.r_packet = m_rep_pkt;
		r.r_offset = m_rep_off[15:0];
		r.heart_rate = m_hr[15:0];
		beat_queue.push_back(r);
	endtask

	task automatic send_word(input ecgr_pkg::in_word_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (in_stall);
		predict_beat(w);
		words_sent++;
	endtask

	task automatic drop_valid();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		drop_valid();
		wait (beat_queue.size() == 0);
		repeat (70) @(posedge clk);
	endtask

	task automatic write_rate(input logic [10:0] rate);
		wait_drained();
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= ecgr_pkg::REG_SAMPLE_RATE;
		pwdata <= {$urandom_range(1, 0) ? 21'h1FFFFF : 21'h0, rate};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		m_rate = rate;
	endtask

	// ecg-like sample stream: quiet baseline with periodic spikes, some noise
	int unsigned gen_pkt, gen_in_pkt, gen_period, gen_phase;

	task automatic send_stream(input int n);
		ecgr_pkg::in_word_t w;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 15) begin
				w.processed_sample = 16'($urandom);
				w.raw_sample = 16'($urandom);
				w.packet_number = $urandom;
			end else begin
				if (gen_phase == 0) begin
					w.processed_sample = 16'($urandom_range(65535, 20000));
					w.raw_sample = 16'($urandom_range(32767, 8000));
				end else begin
					w.processed_sample = 16'($urandom_range(300));
					w.raw_sample = 16'($urandom_range(16000) - 8000);
				end
				w.packet_number = gen_pkt;
				gen_phase = (gen_phase + 1 >= gen_period) ? 0 : gen_phase + 1;
				if (gen_phase == 0 && $urandom_range(3) == 0) gen_period = $urandom_range(40, 2);
				gen_in_pkt++;
				if (gen_in_pkt >= 50) begin
					gen_in_pkt = 0;
					gen_pkt++;
				end
			end
			send_word(w);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		ecgr_pkg::out_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			words_checked++;
			if (beat_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected word %p", out_data);
			end else begin
				want = beat_queue.pop_front();
				if (want.r_found) beats_seen++;
				if (out_data.r_found !== want.r_found || out_data.r_packet !== want.r_packet ||
				    out_data.r_offset !== want.r_offset ||
				    out_data.heart_rate !== want.heart_rate) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p got %p", want, out_data);
				end
			end
		end
	end

	// receiver back-pressure
	always @(negedge clk)
		out_stall <= ($urandom_range(99) < recv_idle_pct);

	task automatic test_directed();
		ecgr_pkg::in_word_t w;
		logic [15:0] procs [6] = '{16'd0, 16'd65535, 16'd0, 16'd9, 16'd65535, 16'd65535};
		logic [15:0] raws  [6] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h7FFF};
		send_idle_pct = 0; recv_idle_pct = 0;
		for (int i = 0; i < 6; i++) begin
			w.processed_sample = procs[i];
			w.raw_sample = raws[i];
			w.packet_number = (i < 3) ? 32'd0 : 32'hFFFF_FFFF;
			send_word(w);
		end
		// alternate across threshold with a steady packet
		for (int i = 0; i < 10; i++) begin
			w.processed_sample = i[0] ? 16'd40000 : 16'd1;
			w.raw_sample = 16'(i * 1000);
			w.packet_number = 32'h5555_AAAA;
			send_word(w);
		end
	endtask

	task automatic test_rate_extremes();
		write_rate(11'd0);
		send_stream(30);
		write_rate(11'd1);
		send_stream(30);
		write_rate(11'd2047);
		send_stream(20);
		write_rate(11'd2000);
		send_stream(40);
		// shrink the window below its current position
		write_rate(11'd3);
		send_stream(30);
	endtask

	task automatic test_random_sender_light();
		send_idle_pct = 32; recv_idle_pct = 80;
		write_rate(11'd8);
		send_stream(150);
		drop_valid();
		wait (beat_queue.size() == 0);
		send_stream(150);
	endtask

	task automatic test_random_sender_heavy();
		send_idle_pct = 80; recv_idle_pct = 32;
		write_rate(11'd250);
		send_stream(300);
	endtask

	task automatic test_random_no_idle();
		send_idle_pct = 0; recv_idle_pct = 0;
		write_rate(11'd16);
		send_stream(300);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0; in_data = '0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		mismatches = 0; words_sent = 0; words_checked = 0; beats_seen = 0;
		send_idle_pct = 0; recv_idle_pct = 0;
		gen_pkt = $urandom; gen_in_pkt = 0; gen_period = 10; gen_phase = 1;
		model_reset();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_rate_extremes();
		test_random_sender_light();
		test_random_sender_heavy();
		test_random_no_idle();

		wait_drained();
		repeat (100) @(posedge clk);
		if (beat_queue.size() != 0) mismatches++;
		$display("covered %0d samples, %0d results checked, %0d beats, rates 0 to 2047",
		         words_sent, words_checked, beats_seen);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
